>>> rtl/ssfp_pkg.sv
// ----------------------------------------------------------------------------
// ssfp_pkg
// Shared types and constants of the servo status frame parser.
// ----------------------------------------------------------------------------
package ssfp_pkg;

  // Default depth of the parameter store
  localparam int MAX_READ_DEF = 32;

  // Field widths
  localparam int BYTE_W    = 8;
  localparam int CNT_W     = 6;
  localparam int CFG_IDX_W = 2;
  localparam int OUT_W     = 32;

  // Register reset values
  localparam logic [BYTE_W-1:0] HEADER_RST = 8'hFF;
  localparam logic [BYTE_W-1:0] ID_RST     = 8'h01;
  localparam logic [CNT_W-1:0]  COUNT_RST  = 6'd0;

  // Smallest legal length field
  localparam logic [BYTE_W-1:0] MIN_LEN = 8'd2;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEADER = 2'd0,
    CFG_ID     = 2'd1,
    CFG_COUNT  = 2'd2
  } cfg_idx_t;

  // Status codes of a status item
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_HDR  = 3'd1,
    ST_WRONG_ID = 3'd2,
    ST_SHORT    = 3'd3,
    ST_SERVO    = 3'd4,
    ST_BAD_SUM  = 3'd5,
    ST_TIMEOUT  = 3'd6
  } status_code_t;

  // Controller states
  typedef enum logic [3:0] {
    S_HDR1     = 4'd0,
    S_HDR2     = 4'd1,
    S_ID       = 4'd2,
    S_LEN      = 4'd3,
    S_ERR      = 4'd4,
    S_PARAM    = 4'd5,
    S_CHK      = 4'd6,
    S_DRAIN_RD = 4'd7,
    S_DRAIN_LD = 4'd8
  } state_t;

  // Datapath operations
  typedef enum logic [3:0] {
    DP_NONE   = 4'd0,
    DP_ID     = 4'd1,
    DP_LEN    = 4'd2,
    DP_ERR    = 4'd3,
    DP_PARAM  = 4'd4,
    DP_FAIL   = 4'd5,
    DP_OK     = 4'd6,
    DP_READ   = 4'd7,
    DP_SEND   = 4'd8
  } dp_op_t;

  // Controller to datapath
  typedef struct packed {
    dp_op_t       op;
    status_code_t code;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic hdr_match;
    logic id_match;
    logic len_short;
    logic left_le2;
    logic err_nonzero;
    logic sum_ok;
    logic deliver_zero;
    logic drain_last;
    logic out_free;
  } dp_stat_t;

endpackage

>>> rtl/ssfp_ctrl.sv
// ----------------------------------------------------------------------------
// ssfp_ctrl
// Frame state machine: walks the reply fields and the parameter drain.
// ----------------------------------------------------------------------------
module ssfp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_timeout,
  output logic                in_ready,
  input  ssfp_pkg::dp_stat_t  stat,
  output ssfp_pkg::dp_cmd_t   cmd
);

  ssfp_pkg::state_t state;
  ssfp_pkg::state_t state_next;
  logic             rx_state;
  logic             take;

  // Byte-taking states
  always_comb begin
    rx_state = (state != ssfp_pkg::S_DRAIN_RD) && (state != ssfp_pkg::S_DRAIN_LD);
  end

  assign in_ready = rx_state && stat.out_free;
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ssfp_pkg::S_HDR1;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    if (take && in_timeout) begin
      state_next = ssfp_pkg::S_HDR1;
    end else begin
      unique case (state)
        ssfp_pkg::S_HDR1: begin
          if (take) state_next = stat.hdr_match ? ssfp_pkg::S_HDR2 : ssfp_pkg::S_HDR1;
        end
        ssfp_pkg::S_HDR2: begin
          if (take) state_next = stat.hdr_match ? ssfp_pkg::S_ID : ssfp_pkg::S_HDR1;
        end
        ssfp_pkg::S_ID: begin
          if (take) state_next = stat.id_match ? ssfp_pkg::S_LEN : ssfp_pkg::S_HDR1;
        end
        ssfp_pkg::S_LEN: begin
          if (take) state_next = stat.len_short ? ssfp_pkg::S_HDR1 : ssfp_pkg::S_ERR;
        end
        ssfp_pkg::S_ERR, ssfp_pkg::S_PARAM: begin
          if (take) state_next = stat.left_le2 ? ssfp_pkg::S_CHK : ssfp_pkg::S_PARAM;
        end
        ssfp_pkg::S_CHK: begin
          if (take) begin
            if (stat.err_nonzero || !stat.sum_ok || stat.deliver_zero) begin
              state_next = ssfp_pkg::S_HDR1;
            end else begin
              state_next = ssfp_pkg::S_DRAIN_RD;
            end
          end
        end
        ssfp_pkg::S_DRAIN_RD: begin
          state_next = ssfp_pkg::S_DRAIN_LD;
        end
        ssfp_pkg::S_DRAIN_LD: begin
          if (stat.out_free) begin
            state_next = stat.drain_last ? ssfp_pkg::S_HDR1 : ssfp_pkg::S_DRAIN_RD;
          end
        end
        default: begin
          state_next = ssfp_pkg::S_HDR1;
        end
      endcase
    end
  end

  // Datapath commands
  always_comb begin
    cmd.op   = ssfp_pkg::DP_NONE;
    cmd.code = ssfp_pkg::ST_OK;
    if (take && in_timeout) begin
      cmd.op   = ssfp_pkg::DP_FAIL;
      cmd.code = ssfp_pkg::ST_TIMEOUT;
    end else begin
      unique case (state)
        ssfp_pkg::S_HDR1, ssfp_pkg::S_HDR2: begin
          if (take && !stat.hdr_match) begin
            cmd.op   = ssfp_pkg::DP_FAIL;
            cmd.code = ssfp_pkg::ST_BAD_HDR;
          end
        end
        ssfp_pkg::S_ID: begin
          if (take) begin
            if (stat.id_match) begin
              cmd.op = ssfp_pkg::DP_ID;
            end else begin
              cmd.op   = ssfp_pkg::DP_FAIL;
              cmd.code = ssfp_pkg::ST_WRONG_ID;
            end
          end
        end
        ssfp_pkg::S_LEN: begin
          if (take) begin
            if (stat.len_short) begin
              cmd.op   = ssfp_pkg::DP_FAIL;
              cmd.code = ssfp_pkg::ST_SHORT;
            end else begin
              cmd.op = ssfp_pkg::DP_LEN;
            end
          end
        end
        ssfp_pkg::S_ERR: begin
          if (take) cmd.op = ssfp_pkg::DP_ERR;
        end
        ssfp_pkg::S_PARAM: begin
          if (take) cmd.op = ssfp_pkg::DP_PARAM;
        end
        ssfp_pkg::S_CHK: begin
          if (take) begin
            // Servo error wins over a bad checksum
            priority if (stat.err_nonzero) begin
              cmd.op   = ssfp_pkg::DP_FAIL;
              cmd.code = ssfp_pkg::ST_SERVO;
            end else if (!stat.sum_ok) begin
              cmd.op   = ssfp_pkg::DP_FAIL;
              cmd.code = ssfp_pkg::ST_BAD_SUM;
            end else begin
              cmd.op = ssfp_pkg::DP_OK;
            end
          end
        end
        ssfp_pkg::S_DRAIN_RD: begin
          cmd.op = ssfp_pkg::DP_READ;
        end
        ssfp_pkg::S_DRAIN_LD: begin
          if (stat.out_free) cmd.op = ssfp_pkg::DP_SEND;
        end
        default: begin
          cmd.op = ssfp_pkg::DP_NONE;
        end
      endcase
    end
  end

endmodule

>>> rtl/ssfp_dp.sv
// ----------------------------------------------------------------------------
// ssfp_dp
// Frame datapath: config registers, running sum, parameter store and the
// output register.
// ----------------------------------------------------------------------------
module ssfp_dp #(
  parameter int MAX_READ = ssfp_pkg::MAX_READ_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [ssfp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ssfp_pkg::BYTE_W-1:0]    cfg_data,
  input  logic [ssfp_pkg::BYTE_W-1:0]    rx_byte,
  input  ssfp_pkg::dp_cmd_t              cmd,
  output ssfp_pkg::dp_stat_t             stat,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic                           out_is_status,
  output logic [2:0]                     out_status,
  output logic [ssfp_pkg::BYTE_W-1:0]    out_byte,
  output logic [ssfp_pkg::CNT_W-1:0]     out_count,
  output logic [ssfp_pkg::BYTE_W-1:0]    out_err,
  output logic                           out_last
);

  localparam int IDX_W = (MAX_READ > 1) ? $clog2(MAX_READ) : 1;
  localparam logic [ssfp_pkg::CNT_W-1:0] STORE_MAX = ssfp_pkg::CNT_W'(MAX_READ);

  // Configuration
  logic [ssfp_pkg::BYTE_W-1:0] header_byte;
  logic [ssfp_pkg::BYTE_W-1:0] expected_id;
  logic [ssfp_pkg::CNT_W-1:0]  read_count;

  // Frame state
  logic [ssfp_pkg::BYTE_W-1:0] running_sum;
  logic [ssfp_pkg::BYTE_W-1:0] bytes_left;
  logic [ssfp_pkg::BYTE_W-1:0] error_value;
  logic [ssfp_pkg::CNT_W-1:0]  stored_count;
  logic [ssfp_pkg::CNT_W-1:0]  deliver_count;
  logic [ssfp_pkg::CNT_W-1:0]  drain_idx;
  logic [ssfp_pkg::CNT_W-1:0]  deliver_next;

  // Parameter store
  logic [ssfp_pkg::BYTE_W-1:0] store_mem [MAX_READ];
  logic [ssfp_pkg::BYTE_W-1:0] rd_data;
  logic                        store_we;
  logic                        out_load;

  // Delivered count is the lesser of request and stored bytes
  assign deliver_next = (read_count < stored_count) ? read_count : stored_count;

  assign store_we = (cmd.op == ssfp_pkg::DP_PARAM) && (stored_count < STORE_MAX);
  assign out_load = (cmd.op == ssfp_pkg::DP_FAIL) || (cmd.op == ssfp_pkg::DP_OK) ||
                    (cmd.op == ssfp_pkg::DP_SEND);

  // Status toward the controller
  always_comb begin
    stat.hdr_match    = (rx_byte == header_byte);
    stat.id_match     = (rx_byte == expected_id);
    stat.len_short    = (rx_byte < ssfp_pkg::MIN_LEN);
    stat.left_le2     = (bytes_left <= ssfp_pkg::MIN_LEN);
    stat.err_nonzero  = (error_value != '0);
    stat.sum_ok       = ((~running_sum) == rx_byte);
    stat.deliver_zero = (deliver_next == '0);
    stat.drain_last   = ((drain_idx + ssfp_pkg::CNT_W'(1)) == deliver_count);
    stat.out_free     = !out_valid || out_ready;
  end

  // Config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte <= ssfp_pkg::HEADER_RST;
      expected_id <= ssfp_pkg::ID_RST;
      read_count  <= ssfp_pkg::COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ssfp_pkg::CFG_HEADER: header_byte <= cfg_data;
        ssfp_pkg::CFG_ID:     expected_id <= cfg_data;
        ssfp_pkg::CFG_COUNT:  read_count  <= cfg_data[ssfp_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Frame registers
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum   <= '0;
      bytes_left    <= '0;
      error_value   <= '0;
      stored_count  <= '0;
      deliver_count <= '0;
      drain_idx     <= '0;
    end else begin
      unique case (cmd.op)
        ssfp_pkg::DP_ID: begin
          running_sum <= rx_byte;
        end
        ssfp_pkg::DP_LEN: begin
          running_sum  <= running_sum + rx_byte;
          bytes_left   <= rx_byte;
          error_value  <= '0;
          stored_count <= '0;
        end
        ssfp_pkg::DP_ERR: begin
          error_value <= rx_byte;
          running_sum <= running_sum + rx_byte;
          bytes_left  <= bytes_left - 8'd1;
        end
        ssfp_pkg::DP_PARAM: begin
          running_sum <= running_sum + rx_byte;
          bytes_left  <= bytes_left - 8'd1;
          if (store_we) stored_count <= stored_count + ssfp_pkg::CNT_W'(1);
        end
        ssfp_pkg::DP_FAIL, ssfp_pkg::DP_OK: begin
          // Return to idle; keep the count for the drain
          running_sum   <= '0;
          bytes_left    <= '0;
          error_value   <= '0;
          stored_count  <= '0;
          deliver_count <= deliver_next;
          drain_idx     <= '0;
        end
        ssfp_pkg::DP_SEND: begin
          drain_idx <= drain_idx + ssfp_pkg::CNT_W'(1);
        end
        default: ;
      endcase
    end
  end

  // Store write and registered read
  always_ff @(posedge clk) begin
    if (store_we) begin
      store_mem[stored_count[IDX_W-1:0]] <= rx_byte;
    end
    if (cmd.op == ssfp_pkg::DP_READ) begin
      rd_data <= store_mem[drain_idx[IDX_W-1:0]];
    end
  end

  // Output valid: set on load, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      unique case (cmd.op)
        ssfp_pkg::DP_FAIL: begin
          out_is_status <= 1'b1;
          out_status    <= cmd.code;
          out_byte      <= '0;
          out_count     <= '0;
          out_err       <= error_value;
          out_last      <= 1'b1;
        end
        ssfp_pkg::DP_OK: begin
          out_is_status <= 1'b1;
          out_status    <= ssfp_pkg::ST_OK;
          out_byte      <= '0;
          out_count     <= deliver_next;
          out_err       <= error_value;
          out_last      <= (deliver_next == '0);
        end
        default: begin
          out_is_status <= 1'b0;
          out_status    <= ssfp_pkg::ST_OK;
          out_byte      <= rd_data;
          out_count     <= deliver_count;
          out_err       <= error_value;
          out_last      <= stat.drain_last;
        end
      endcase
    end
  end

endmodule

>>> rtl/servo_status_frame_parser_core.sv
// ----------------------------------------------------------------------------
// servo_status_frame_parser_core
// Parser for servo status replies: HDR HDR ID LEN ERR PARAM... CHK.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one received line byte per request (tdata) or a read
//   timeout event (tuser). m_* carries result requests: one status item per
//   reply, followed on success by up to read_count parameter bytes.
//   cfg_* writes header_byte (0), expected_id (1) and read_count (2); write
//   it only while the parser is idle.
// Results:
//   A byte that ends a frame or fails a check shows its status item in the
//   cycle after it is taken; other bytes give no result. After a good
//   checksum with no servo error, each byte to deliver gets a registered
//   read of the parameter store (S_DRAIN_RD) and then goes to the
//   output register (S_DRAIN_LD); no input is taken during the drain.
// Reset:
//   The parser waits for the first header byte; registers return to 0xFF,
//   1 and 0.
// Stall:
//   The output register holds its item; s_tready drops while that register
//   is full and not being taken, and the drain pauses.
// ----------------------------------------------------------------------------
module servo_status_frame_parser_core #(
  parameter int MAX_READ = ssfp_pkg::MAX_READ_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // rx_byte[7:0]
  input  logic [7:0]                     s_tdata,
  // timed_out
  input  logic                           s_tuser,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // status[2:0], data_byte[10:3], data_count[16:11], servo_error[24:17]
  output logic [ssfp_pkg::OUT_W-1:0]     m_tdata,
  // is_status
  output logic                           m_tuser,
  output logic                           m_tlast,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ssfp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ssfp_pkg::BYTE_W-1:0]    cfg_data
);

  ssfp_pkg::dp_cmd_t           cmd;
  ssfp_pkg::dp_stat_t          stat;
  logic [2:0]                  out_status;
  logic [ssfp_pkg::BYTE_W-1:0] out_byte;
  logic [ssfp_pkg::CNT_W-1:0]  out_count;
  logic [ssfp_pkg::BYTE_W-1:0] out_err;

  // Configuration writes are always taken
  assign cfg_ready = 1'b1;

  ssfp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_timeout (s_tuser),
    .in_ready   (s_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  ssfp_dp #(
    .MAX_READ (MAX_READ)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .rx_byte       (s_tdata),
    .cmd           (cmd),
    .stat          (stat),
    .out_ready     (m_tready),
    .out_valid     (m_tvalid),
    .out_is_status (m_tuser),
    .out_status    (out_status),
    .out_byte      (out_byte),
    .out_count     (out_count),
    .out_err       (out_err),
    .out_last      (m_tlast)
  );

  // Pack result fields, lowest first
  assign m_tdata = {7'd0, out_err, out_count, out_byte, out_status};

endmodule
